// ===== hdl/bounded_deque_buffer_macros.svh =====
// Assertion macros used by the deque buffer control module.
`ifndef BOUNDED_DEQUE_BUFFER_MACROS_SVH
`define BOUNDED_DEQUE_BUFFER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BDB_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BDB_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== hdl/bdb_pkg.sv =====
// Package with the constants, operation codes and types of the deque buffer.
package bdb_pkg;

	localparam int BDB_DEPTH      = 16;
	localparam int BDB_WORD_WIDTH = 32;
	localparam int BDB_OP_W       = 3;
	localparam int BDB_CNT_W      = 5;

	localparam logic [BDB_CNT_W-1:0] BDB_CAP_RESET = 5'd16;

	localparam logic [BDB_OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [BDB_OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [BDB_OP_W-1:0] OP_POP        = 3'd2;
	localparam logic [BDB_OP_W-1:0] OP_PEEK       = 3'd3;
	localparam logic [BDB_OP_W-1:0] OP_CLEAR      = 3'd4;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} bdb_mem_ctl_t;

	typedef struct packed {
		logic                 success;
		logic [BDB_CNT_W-1:0] held_count;
		logic                 is_full;
		logic                 is_empty;
		logic                 use_mem;
	} bdb_status_t;

endpackage

// ===== hdl/bdb_if.sv =====
// Request, response and configuration channel interfaces of the deque buffer.
interface bdb_req_if import bdb_pkg::*; #(
	parameter int WORD_WIDTH = BDB_WORD_WIDTH
);
	logic                  valid;
	logic                  ready;
	logic [BDB_OP_W-1:0]   operation;
	logic [WORD_WIDTH-1:0] item_data;

	modport source (output valid, operation, item_data, input ready);
	modport sink (input valid, operation, item_data, output ready);
endinterface

interface bdb_rsp_if import bdb_pkg::*; #(
	parameter int WORD_WIDTH = BDB_WORD_WIDTH
);
	logic                  valid;
	logic                  ready;
	logic                  success;
	logic [WORD_WIDTH-1:0] read_data;
	logic [BDB_CNT_W-1:0]  held_count;
	logic                  is_full;
	logic                  is_empty;

	modport source (output valid, success, read_data, held_count, is_full, is_empty,
		input ready);
	modport sink (input valid, success, read_data, held_count, is_full, is_empty,
		output ready);
endinterface

interface bdb_cfg_if import bdb_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [BDB_CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/bdb_store.sv =====
// Entry memory of the deque buffer with one port and a registered read.
module bdb_store import bdb_pkg::*; #(
	parameter int DEPTH      = BDB_DEPTH,
	parameter int WORD_WIDTH = BDB_WORD_WIDTH,
	localparam int PTR_W     = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  bdb_mem_ctl_t          mem_ctl,
	input  logic [PTR_W-1:0]      mem_addr,
	input  logic [WORD_WIDTH-1:0] wr_data,
	output logic [WORD_WIDTH-1:0] rd_data_s1
);

	logic [WORD_WIDTH-1:0] entry_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			entry_mem[mem_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_data_s1 <= entry_mem[mem_addr];
		end
	end

endmodule

// ===== hdl/bdb_ctrl.sv =====
// Pointer and count control, request decode and response pipeline of the deque buffer.
`include "bounded_deque_buffer_macros.svh"

module bdb_ctrl import bdb_pkg::*; #(
	parameter int DEPTH      = BDB_DEPTH,
	parameter int WORD_WIDTH = BDB_WORD_WIDTH,
	localparam int PTR_W     = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bdb_cfg_if.sink               cfg,
	bdb_req_if.sink               req,
	bdb_rsp_if.source             rsp,
	output bdb_mem_ctl_t          mem_ctl,
	output logic [PTR_W-1:0]      mem_addr,
	input  logic [WORD_WIDTH-1:0] rd_data_s1
);

	localparam int CAP_LIM = (DEPTH < 31) ? DEPTH : 31;
	localparam int SUM_W   = ((PTR_W > BDB_CNT_W) ? PTR_W : BDB_CNT_W) + 1;

	logic [BDB_CNT_W-1:0] cap_q;
	logic [PTR_W-1:0]     front_q;
	logic [BDB_CNT_W-1:0] count_q;

	logic                 s1_valid_q;
	bdb_status_t          s1_st_q;
	logic                 out_valid_q;
	bdb_status_t          out_st_q;
	logic [WORD_WIDTH-1:0] out_data_q;

	logic                 accept;
	logic                 out_free;
	logic                 s1_adv;
	logic [BDB_CNT_W-1:0] usable;
	logic                 can_push;
	logic                 not_empty;
	logic [SUM_W-1:0]     back_sum;
	logic [PTR_W-1:0]     back_slot;
	logic [PTR_W-1:0]     front_dec;
	logic [PTR_W-1:0]     front_inc;
	logic [PTR_W-1:0]     front_nx;
	logic [BDB_CNT_W-1:0] count_nx;
	bdb_status_t          st_nx;

	assign cfg.ready = 1'b1;

	assign out_free  = !out_valid_q || rsp.ready;
	assign s1_adv    = s1_valid_q && out_free;
	assign req.ready = !s1_valid_q || out_free;
	assign accept    = req.valid && req.ready;

	assign usable    = (cap_q > BDB_CNT_W'(CAP_LIM)) ? BDB_CNT_W'(CAP_LIM) : cap_q;
	assign can_push  = count_q < usable;
	assign not_empty = count_q != '0;

	assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
	assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
		: PTR_W'(back_sum);
	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		front_nx       = front_q;
		count_nx       = count_q;
		mem_ctl        = '0;
		mem_addr       = front_q;
		st_nx.success  = 1'b0;
		st_nx.use_mem  = 1'b0;
		case (req.operation)
			OP_PUSH_BACK: begin
				if (can_push) begin
					mem_ctl.wr_en = accept;
					mem_addr      = back_slot;
					count_nx      = count_q + 1'b1;
					st_nx.success = 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (can_push) begin
					mem_ctl.wr_en = accept;
					mem_addr      = front_dec;
					front_nx      = front_dec;
					count_nx      = count_q + 1'b1;
					st_nx.success = 1'b1;
				end
			end
			OP_POP: begin
				if (not_empty) begin
					mem_ctl.rd_en = accept;
					front_nx      = front_inc;
					count_nx      = count_q - 1'b1;
					st_nx.success = 1'b1;
					st_nx.use_mem = 1'b1;
				end
			end
			OP_PEEK: begin
				if (not_empty) begin
					mem_ctl.rd_en = accept;
					st_nx.success = 1'b1;
					st_nx.use_mem = 1'b1;
				end
			end
			OP_CLEAR: begin
				front_nx      = '0;
				count_nx      = '0;
				st_nx.success = 1'b1;
			end
			default: begin
			end
		endcase
		st_nx.held_count = count_nx;
		st_nx.is_full    = count_nx >= usable;
		st_nx.is_empty   = count_nx == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= BDB_CAP_RESET;
			front_q     <= '0;
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (accept) begin
				front_q <= front_nx;
				count_q <= count_nx;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_st_q <= st_nx;
		end
		if (s1_adv) begin
			out_st_q   <= s1_st_q;
			out_data_q <= s1_st_q.use_mem ? rd_data_s1 : '1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.success    = out_st_q.success;
	assign rsp.read_data  = out_data_q;
	assign rsp.held_count = out_st_q.held_count;
	assign rsp.is_full    = out_st_q.is_full;
	assign rsp.is_empty   = out_st_q.is_empty;

	`BDB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= BDB_CNT_W'(CAP_LIM), "count above limit")
	`BDB_ASSERT_NOW(a_front_range, 1'b1, 32'(front_q) < DEPTH, "front pointer out of range")
	`BDB_ASSERT_NEXT(a_pop_count, accept && req.operation == OP_POP && count_q != '0, count_q == BDB_CNT_W'($past(count_q) - 1'b1), "pop did not decrement")
	`BDB_ASSERT_NOW(a_mem_success, s1_valid_q && s1_st_q.use_mem, s1_st_q.success, "memory read on failed request")

endmodule

// ===== hdl/bounded_deque_buffer.sv =====
// Top level of the deque buffer: a bounded ring of words with front and back push.
// An accepted request passes the memory read stage and then the response register before its result is offered.
// Throughput: one request per cycle while the response side takes results, set by the single-port entry memory.
// A response register and a memory read stage let requests continue while a result waits.
// Reset clears the pointer, the count and both stages and sets the capacity to 16.
// Entry memory contents are not reset; no clearing pass is needed.
module bounded_deque_buffer import bdb_pkg::*; #(
	parameter int DEPTH      = BDB_DEPTH,
	parameter int WORD_WIDTH = BDB_WORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	bdb_cfg_if.sink   cfg,
	bdb_req_if.sink   req,
	bdb_rsp_if.source rsp
);

	localparam int PTR_W = $clog2(DEPTH);

	bdb_mem_ctl_t          mem_ctl;
	logic [PTR_W-1:0]      mem_addr;
	logic [WORD_WIDTH-1:0] rd_data_s1;

	bdb_ctrl #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.rd_data_s1 (rd_data_s1)
	);

	bdb_store #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_store (
		.clk        (clk),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.wr_data    (req.item_data),
		.rd_data_s1 (rd_data_s1)
	);

endmodule
